### rtl/core/accel_tilt_angles_core_defines.svh
// Assertion macros for the tilt angle core
`ifndef ACCEL_TILT_ANGLES_CORE_DEFINES_SVH
`define ACCEL_TILT_ANGLES_CORE_DEFINES_SVH

// Implication checked on every rising clock edge, skipped during reset
`define ATA_ASSERT_IMP(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising clock edge, skipped during reset
`define ATA_ASSERT_NXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ata_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_pkg
// Shared types and constants of the tilt angle core.
// ----------------------------------------------------------------------------
package ata_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW = 15;
	localparam int unsigned InW = 16;
	localparam int unsigned AxisW = 17;
	localparam int unsigned GuardBits = 8;
	localparam int unsigned VecW = 46;
	localparam int unsigned AngW = 28;
	localparam int unsigned TabLen = 24;
	localparam int unsigned RollW = 15;
	localparam int unsigned PitchW = 16;

	localparam logic [CfgIdxW-1:0] REG_COUNTS_PER_G = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_OFFSET_X = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_OFFSET_Y = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_OFFSET_Z = 2'd3;

	localparam logic signed [AngW-1:0] ANG_180 = 28'sd11796480;
	localparam logic [15:0] INV_GAIN = 16'd39797;
	localparam int signed ROLL_LIM = 11520;
	localparam int signed PITCH_LIM = 23040;

	typedef logic signed [VecW-1:0] vec_t;
	typedef logic signed [AngW-1:0] ang_t;

	typedef struct packed {
		logic signed [InW-1:0] accel_x_raw;
		logic signed [InW-1:0] accel_y_raw;
		logic signed [InW-1:0] accel_z_raw;
	} sample_t;

	typedef struct packed {
		logic signed [RollW-1:0] roll_deg;
		logic signed [PitchW-1:0] pitch_deg;
	} angles_t;

	typedef struct packed {
		logic valid;
		vec_t x;
		vec_t y;
		ang_t acc;
	} cordic_t;

	function automatic ang_t atan_entry(input int unsigned idx);
		ang_t r;
		r = '0;
		case (idx)
			0: r = 28'sd2949120;
			1: r = 28'sd1740967;
			2: r = 28'sd919879;
			3: r = 28'sd466945;
			4: r = 28'sd234379;
			5: r = 28'sd117304;
			6: r = 28'sd58666;
			7: r = 28'sd29335;
			8: r = 28'sd14668;
			9: r = 28'sd7334;
			10: r = 28'sd3667;
			11: r = 28'sd1833;
			12: r = 28'sd917;
			13: r = 28'sd458;
			14: r = 28'sd229;
			15: r = 28'sd115;
			16: r = 28'sd57;
			17: r = 28'sd29;
			18: r = 28'sd14;
			19: r = 28'sd7;
			20: r = 28'sd4;
			21: r = 28'sd2;
			22: r = 28'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/ata_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface ata_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ata_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_cordic_cell
// One vectoring micro-rotation with its stage register.
// ----------------------------------------------------------------------------
module ata_cordic_cell #(
	parameter int unsigned STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input ata_pkg::cordic_t din,
	output ata_pkg::cordic_t dout
);
	ata_pkg::vec_t xs;
	ata_pkg::vec_t ys;
	ata_pkg::vec_t xn;
	ata_pkg::vec_t yn;
	ata_pkg::ang_t an;
	logic valid_q;
	ata_pkg::vec_t x_q;
	ata_pkg::vec_t y_q;
	ata_pkg::ang_t acc_q;

	always_comb begin
		xs = din.x >>> STEP;
		ys = din.y >>> STEP;
		if (!din.y[ata_pkg::VecW-1]) begin
			xn = din.x + ys;
			yn = din.y - xs;
			an = din.acc + ata_pkg::atan_entry(STEP);
		end else begin
			xn = din.x - ys;
			yn = din.y + xs;
			an = din.acc - ata_pkg::atan_entry(STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= xn;
			y_q <= yn;
			acc_q <= an;
		end
	end

	assign dout = '{valid: valid_q, x: x_q, y: y_q, acc: acc_q};
endmodule

### rtl/core/ata_cordic_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_cordic_chain
// Row of vectoring cells, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module ata_cordic_chain #(
	parameter int unsigned STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input ata_pkg::cordic_t din,
	output ata_pkg::cordic_t dout
);
	ata_pkg::cordic_t link [STEPS+1];

	assign link[0] = din;

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		ata_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.din(link[g]),
			.dout(link[g+1])
		);
	end

	assign dout = link[STEPS];
endmodule

### rtl/core/accel_tilt_angles_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_core
// Pitch and roll from one accelerometer sample by two chained CORDIC rows.
// ----------------------------------------------------------------------------
// channel   dir  payload
// sample    in   accel_x_raw, accel_y_raw, accel_z_raw
// angles    out  roll_deg, pitch_deg
// cfg       in   cfg_we, cfg_idx, cfg_wdata
//
// One request per cycle while the output does not stall; the pipeline is the two
// cell rows plus offset, scale, magnitude, prep and rounding stages.
// Reset clears only stage valid bits and config registers.
// A stall on the output freezes the whole pipeline; ready follows out ready
// or an empty last stage.
// ----------------------------------------------------------------------------
`include "accel_tilt_angles_core_defines.svh"

module accel_tilt_angles_core #(
	parameter int unsigned CORDIC_STEPS = 16,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ata_pkg::CfgIdxW-1:0] cfg_idx,
	input logic [ata_pkg::CfgW-1:0] cfg_wdata,
	ata_stream_if.sink sample,
	ata_stream_if.source angles
);
	localparam int unsigned AW = ata_pkg::AxisW;
	localparam int unsigned VW = ata_pkg::VecW;
	localparam int unsigned GW = ata_pkg::GuardBits;
	localparam int unsigned NA = ata_pkg::AngW;
	localparam int unsigned PitchW_L = ata_pkg::PitchW;

	logic [ata_pkg::CfgW-1:0] cpg_q;
	logic signed [ata_pkg::CfgW-1:0] off_q [3];
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpg_q <= 15'd16384;
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ata_pkg::REG_COUNTS_PER_G: cpg_q <= cfg_wdata;
				ata_pkg::REG_OFFSET_X: off_q[0] <= cfg_wdata;
				ata_pkg::REG_OFFSET_Y: off_q[1] <= cfg_wdata;
				ata_pkg::REG_OFFSET_Z: off_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = angles.ready || !v_o;
	assign sample.ready = en;

	// s1: offset counts and samples
	logic signed [SAMPLE_WIDTH-1:0] smp [3];
	logic signed [SAMPLE_WIDTH-1:0] smp_s1 [3];
	logic [AW-1:0] cnt_s1 [3];
	logic neg_s1 [3];
	logic [ata_pkg::CfgW-1:0] offm [3];
	logic [2*ata_pkg::CfgW-1:0] prod [3];
	assign smp[0] = sample.data.accel_x_raw[SAMPLE_WIDTH-1:0];
	assign smp[1] = sample.data.accel_y_raw[SAMPLE_WIDTH-1:0];
	assign smp[2] = sample.data.accel_z_raw[SAMPLE_WIDTH-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			offm[i] = off_q[i][14] ? 15'(-off_q[i]) : 15'(off_q[i]);
			prod[i] = 30'(offm[i]) * 30'(cpg_q) + 30'd2048;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				smp_s1[i] <= smp[i];
				cnt_s1[i] <= AW'(prod[i] >> 12);
				neg_s1[i] <= off_q[i][14];
			end
		end
	end

	// s2: corrected axes
	logic signed [AW-1:0] c_s2 [3];
	logic signed [AW+1:0] diff [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = (AW+2)'(smp_s1[i]) + (neg_s1[i] ? (AW+2)'(cnt_s1[i])
				: -(AW+2)'(cnt_s1[i]));
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (diff[i] > (AW+2)'(65535)) c_s2[i] <= 17'sd65535;
				else if (diff[i] < -(AW+2)'(65536)) c_s2[i] <= {1'b1, 16'd0};
				else c_s2[i] <= AW'(diff[i]);
			end
		end
	end

	// s3: pitch prep
	ata_pkg::cordic_t p_in, p_out;
	ata_pkg::vec_t px_s3, py_s3;
	ata_pkg::ang_t pacc_s3;
	logic signed [AW-1:0] cx_s3;
	logic nz_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3 <= c_s2[0];
			nz_s3 <= (c_s2[1] != '0) || (c_s2[2] != '0);
			px_s3 <= (c_s2[2][AW-1] ? -VW'(c_s2[2]) : VW'(c_s2[2])) <<< GW;
			py_s3 <= (c_s2[2][AW-1] ? -VW'(c_s2[1]) : VW'(c_s2[1])) <<< GW;
			pacc_s3 <= !c_s2[2][AW-1] ? '0
				: (c_s2[1][AW-1] ? -ata_pkg::ANG_180 : ata_pkg::ANG_180);
		end
	end
	assign p_in = '{valid: v_s3, x: px_s3, y: py_s3, acc: pacc_s3};

	ata_cordic_chain #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .din(p_in), .dout(p_out)
	);

	// side delay of x and nonzero flag along the pitch row
	logic signed [AW-1:0] cx_d [CORDIC_STEPS+1];
	logic nz_d [CORDIC_STEPS+1];
	assign cx_d[0] = cx_s3;
	assign nz_d[0] = nz_s3;
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				cx_d[g+1] <= cx_d[g];
				nz_d[g+1] <= nz_d[g];
			end
		end
	end

	// s4: magnitude product
	logic signed [VW+17:0] mp_s4;
	ata_pkg::ang_t pa_s4;
	logic signed [AW-1:0] cx_s4;
	logic nz_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			mp_s4 <= (VW+18)'(p_out.x) * $signed({1'b0, ata_pkg::INV_GAIN}) + 32768;
			pa_s4 <= p_out.acc;
			cx_s4 <= cx_d[CORDIC_STEPS];
			nz_s4 <= nz_d[CORDIC_STEPS];
		end
	end

	// s5: roll prep
	ata_pkg::cordic_t r_in, r_out;
	ata_pkg::vec_t rx_s5, ry_s5;
	logic signed [VW+1:0] mag;
	logic signed [PitchW_L-1:0] pitch_s5;
	logic signed [NA-1:0] pr;
	always_comb begin
		mag = (VW+2)'(mp_s4 >>> 16);
		if (!nz_s4 || mag < 0) mag = '0;
		pr = (pa_s4 + NA'(256)) >>> 9;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s5 <= VW'(mag);
			ry_s5 <= -(VW'(cx_s4) <<< GW);
			if (!nz_s4) pitch_s5 <= '0;
			else if (pr > NA'(ata_pkg::PITCH_LIM)) pitch_s5 <= 16'sd23040;
			else if (pr < -NA'(ata_pkg::PITCH_LIM)) pitch_s5 <= -16'sd23040;
			else pitch_s5 <= PitchW_L'(pr);
		end
	end
	assign r_in = '{valid: v_s5, x: rx_s5, y: ry_s5, acc: '0};

	ata_cordic_chain #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .din(r_in), .dout(r_out)
	);

	logic signed [PitchW_L-1:0] pd [CORDIC_STEPS+1];
	logic zr_d [CORDIC_STEPS+1];
	assign pd[0] = pitch_s5;
	assign zr_d[0] = (rx_s5 == '0) && (ry_s5 == '0);
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_pdly
		always_ff @(posedge clk) begin
			if (en) begin
				pd[g+1] <= pd[g];
				zr_d[g+1] <= zr_d[g];
			end
		end
	end

	// output stage
	logic signed [NA-1:0] rr;
	logic signed [ata_pkg::RollW-1:0] roll_q;
	logic signed [PitchW_L-1:0] pitch_q;
	assign rr = (r_out.acc + NA'(256)) >>> 9;
	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= pd[CORDIC_STEPS];
			if (zr_d[CORDIC_STEPS]) roll_q <= '0;
			else if (rr > NA'(ata_pkg::ROLL_LIM)) roll_q <= 15'sd11520;
			else if (rr < -NA'(ata_pkg::ROLL_LIM)) roll_q <= -15'sd11520;
			else roll_q <= ata_pkg::RollW'(rr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_o <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= p_out.valid;
			v_s5 <= v_s4;
			v_o <= r_out.valid;
		end
	end

	assign angles.valid = v_o;
	assign angles.data.roll_deg = roll_q;
	assign angles.data.pitch_deg = pitch_q;

	`ATA_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !v_o, sample.ready, "ready low on empty output")
	`ATA_ASSERT_NXT(a_hold_on_stall, clk, arst_n, v_o && !angles.ready, v_o && $stable(roll_q), "result lost on stall")
	`ATA_ASSERT_IMP(a_roll_range, clk, arst_n, v_o, roll_q <= 15'sd11520 && roll_q >= -15'sd11520, "roll out of range")
	`ATA_ASSERT_IMP(a_pitch_range, clk, arst_n, v_o, pitch_q <= 16'sd23040 && pitch_q >= -16'sd23040, "pitch out of range")
endmodule

### tb/accel_tilt_angles_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_core_tb
// Self-checking bench for the tilt angle core: a queue-fed request driver with
// bursty gaps, a stalling result receiver and an in-bench model of the offset
// correction and the two CORDIC passes that predicts roll and pitch.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core_tb;

	localparam int unsigned STEPS = 16;
	localparam int unsigned LATENCY = 2 * STEPS + 6;
	localparam longint CYCLE_LIMIT = 600000;
	localparam longint ATAN_DEG16[STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
		117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ata_pkg::CfgIdxW-1:0] cfg_idx;
	logic [ata_pkg::CfgW-1:0] cfg_wdata;

	ata_stream_if #(.payload_t(ata_pkg::sample_t)) sample_ch ();
	ata_stream_if #(.payload_t(ata_pkg::angles_t)) angles_ch ();

	accel_tilt_angles_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.sample(sample_ch.sink),
		.angles(angles_ch.source)
	);

	// configuration shadow
	logic [ata_pkg::CfgW-1:0] scale_reg;
	logic signed [ata_pkg::CfgW-1:0] off_reg[3];

	ata_pkg::sample_t pending_samples[$];
	ata_pkg::angles_t expected_angles[$];
	int errors = 0;
	int requests_sent = 0;
	int angles_checked = 0;
	int settings_used = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit took = 0;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint offset_counts(logic signed [ata_pkg::CfgW-1:0] off);
		longint o;
		longint mag;
		longint cnt;
		o = off;
		mag = (o < 0) ? -o : o;
		cnt = (mag * longint'(scale_reg) + 2048) >>> 12;
		return (o < 0) ? -cnt : cnt;
	endfunction

	function automatic longint corrected(logic signed [ata_pkg::InW-1:0] raw, int axis);
		longint v;
		v = longint'(raw) - offset_counts(off_reg[axis]);
		if (v < -65536) v = -65536;
		if (v > 65535) v = 65535;
		return v;
	endfunction

	function automatic longint rotate_to_axis(inout longint x, inout longint y);
		longint a;
		longint xs;
		longint ys;
		a = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				a += ATAN_DEG16[i];
			end else begin
				x -= ys;
				y += xs;
				a -= ATAN_DEG16[i];
			end
		end
		return a;
	endfunction

	function automatic longint round_clamp(longint acc, longint lim);
		longint r;
		r = (acc + 256) >>> 9;
		return (r < -lim) ? -lim : ((r > lim) ? lim : r);
	endfunction

	function automatic ata_pkg::angles_t predict_angles(ata_pkg::sample_t s);
		ata_pkg::angles_t r;
		longint cx, cy, cz, px, py, acc, pitch, roll, magn, rx, ry;
		cx = corrected(s.accel_x_raw, 0);
		cy = corrected(s.accel_y_raw, 1);
		cz = corrected(s.accel_z_raw, 2);
		px = cz * 256;
		py = cy * 256;
		pitch = 0;
		roll = 0;
		magn = 0;
		if (cy != 0 || cz != 0) begin
			acc = 0;
			if (px < 0) begin
				acc = (py >= 0) ? longint'(ata_pkg::ANG_180) : -longint'(ata_pkg::ANG_180);
				px = -px;
				py = -py;
			end
			acc += rotate_to_axis(px, py);
			pitch = round_clamp(acc, ata_pkg::PITCH_LIM);
			magn = (px * longint'(ata_pkg::INV_GAIN) + 32768) >>> 16;
			if (magn < 0) magn = 0;
		end
		if (cx != 0 || magn != 0) begin
			rx = magn;
			ry = -cx * 256;
			acc = rotate_to_axis(rx, ry);
			roll = round_clamp(acc, ata_pkg::ROLL_LIM);
		end
		r.roll_deg = roll[ata_pkg::RollW-1:0];
		r.pitch_deg = pitch[ata_pkg::PitchW-1:0];
		return r;
	endfunction

	// acceptance of requests: prediction against the current settings
	always @(posedge clk) begin
		took = sample_ch.valid && sample_ch.ready;
		if (took) begin
			expected_angles = {expected_angles, predict_angles(sample_ch.data)};
			void'(pending_samples.pop_front());
			requests_sent++;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (sample_ch.valid && !took) begin
			sample_ch.valid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			sample_ch.valid <= 1'b0;
		end else begin
			sample_ch.valid <= (pending_samples.size() > 0);
			if (pending_samples.size() > 0) sample_ch.data <= pending_samples[0];
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end
	end

	// result receiver with its own stall pattern and long hold-off
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = 300;
		end
		if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			angles_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: angles_ch.ready <= 1'b1;
				1: angles_ch.ready <= ($urandom_range(0, 3) != 0);
				2: angles_ch.ready <= ($urandom_range(0, 1) != 0);
				default: angles_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		ata_pkg::angles_t got;
		ata_pkg::angles_t want;
		if (arst_n && angles_ch.valid && angles_ch.ready) begin
			got = angles_ch.data;
			if (expected_angles.size() == 0) begin
				$error("unexpected result roll_deg=%0d pitch_deg=%0d",
					got.roll_deg, got.pitch_deg);
				errors++;
			end else begin
				want = expected_angles.pop_front();
				if (got.roll_deg !== want.roll_deg) begin
					$error("roll_deg expected %0d actual %0d", want.roll_deg, got.roll_deg);
					errors++;
				end
				if (got.pitch_deg !== want.pitch_deg) begin
					$error("pitch_deg expected %0d actual %0d", want.pitch_deg, got.pitch_deg);
					errors++;
				end
				angles_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_angles.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(logic [ata_pkg::CfgIdxW-1:0] idx, logic [ata_pkg::CfgW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == ata_pkg::REG_COUNTS_PER_G) scale_reg = val;
		else off_reg[int'(idx) - 1] = val;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || expected_angles.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic apply_setting(int scale, int ox, int oy, int oz);
		drain();
		write_reg(ata_pkg::REG_COUNTS_PER_G, ata_pkg::CfgW'(scale));
		write_reg(ata_pkg::REG_OFFSET_X, ata_pkg::CfgW'(ox));
		write_reg(ata_pkg::REG_OFFSET_Y, ata_pkg::CfgW'(oy));
		write_reg(ata_pkg::REG_OFFSET_Z, ata_pkg::CfgW'(oz));
		settings_used++;
	endtask

	function automatic logic signed [ata_pkg::InW-1:0] near(int axis, int spread);
		longint v;
		v = offset_counts(off_reg[axis]) + $signed($urandom_range(0, 2 * spread)) - spread;
		return v[ata_pkg::InW-1:0];
	endfunction

	function automatic ata_pkg::sample_t random_sample();
		ata_pkg::sample_t s;
		s.accel_x_raw = 16'($urandom);
		s.accel_y_raw = 16'($urandom);
		s.accel_z_raw = 16'($urandom);
		case ($urandom_range(0, 6))
			0, 1: ;
			2: begin
				s.accel_x_raw = near(0, 300);
				s.accel_y_raw = near(1, 300);
				s.accel_z_raw = near(2, 300);
			end
			3: s.accel_x_raw = near(0, 0);
			4: begin
				s.accel_y_raw = near(1, 0);
				s.accel_z_raw = near(2, 0);
			end
			5: s.accel_y_raw = near(1, $urandom_range(0, 2));
			default: begin
				s.accel_x_raw = near(0, 20000);
				s.accel_y_raw = near(1, 20000);
				s.accel_z_raw = near(2, 20000);
			end
		endcase
		return s;
	endfunction

	task automatic queue_sample(int x, int y, int z);
		ata_pkg::sample_t s;
		s.accel_x_raw = x[ata_pkg::InW-1:0];
		s.accel_y_raw = y[ata_pkg::InW-1:0];
		s.accel_z_raw = z[ata_pkg::InW-1:0];
		pending_samples = {pending_samples, s};
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		angles_ch.ready = 1'b0;
		scale_reg = 15'd16384;
		off_reg[0] = '0;
		off_reg[1] = '0;
		off_reg[2] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: zeros, extremes, quadrant edges
		queue_sample(0, 0, 0);
		queue_sample(32767, 32767, 32767);
		queue_sample(-32768, -32768, -32768);
		queue_sample(0, 0, 16384);
		queue_sample(0, 0, -16384);
		queue_sample(0, 5, -16384);
		queue_sample(0, -5, -16384);
		queue_sample(0, 16384, 0);
		queue_sample(0, -16384, 0);
		queue_sample(16384, 0, 0);
		queue_sample(-16384, 0, 0);
		queue_sample(1, 0, 0);
		queue_sample(-1, 0, 0);
		queue_sample(0, 1, 0);
		queue_sample(0, 0, -1);
		queue_sample(32767, -32768, -1);
		queue_sample(-32768, 32767, 1);
		queue_sample(100, -200, 16000);
		queue_sample(-21845, 21845, -10922);
		queue_sample(10922, -21845, 21845);

		// settings: reset values, extremes, zero scale, mid values
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: settings_used++;
				1: apply_setting(2048, -8192, 8192, -8192);
				2: apply_setting(16384, 8192, -8192, 8192);
				3: apply_setting(0, 8192, 8192, -8192);
				4: apply_setting(32767, -16384, 16383, 1);
				5: apply_setting(4096, 4096, -4096, 0);
				6: apply_setting(8192, 0, 0, -8192);
				default: apply_setting($urandom_range(2048, 16384), $urandom_range(0, 16384) - 8192,
					$urandom_range(0, 16384) - 8192, $urandom_range(0, 16384) - 8192);
			endcase
			if (phase == 1) begin
				queue_sample(0, 0, 0);
				queue_sample(32767, -32768, 32767);
			end
			n = 240;
			for (int i = 0; i < n; i++) begin
				pending_samples = {pending_samples, random_sample()};
				if (i == n / 2) hold_requests++;
				if (pending_samples.size() > 64) begin
					while (pending_samples.size() >= 32) @(negedge clk);
				end
			end
		end

		while (pending_samples.size() != 0 || expected_angles.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("%0d sample requests sent, %0d checked over %0d offset and scale settings",
			requests_sent, angles_checked, settings_used);
		$display("including zero vectors, saturated axes and long output stalls");
		if (errors == 0 && expected_angles.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
